[src/tty_line_discipline_core_defines.svh]
// assertion macros for the line discipline core
`ifndef TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TLD_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define TLD_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

[src/tld_pkg.sv]
// ----------------------------------------------------------------------------
// tld_pkg
// types, codes and sizes shared by the line discipline core
// ----------------------------------------------------------------------------
`default_nettype none
package tld_pkg;
   localparam int LINE_DEPTH   = 16;
   localparam int INPUT_DEPTH  = 1024;
   localparam int OUTPUT_DEPTH = 4096;
   localparam int LW  = $clog2(LINE_DEPTH);
   localparam int LLW = $clog2(LINE_DEPTH + 1);
   localparam int IW  = $clog2(INPUT_DEPTH);
   localparam int OW  = $clog2(OUTPUT_DEPTH);

   localparam logic [1:0] OP_KEY  = 2'd0;
   localparam logic [1:0] OP_RDIN = 2'd1;
   localparam logic [1:0] OP_WROUT = 2'd2;
   localparam logic [1:0] OP_RDOUT = 2'd3;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [7:0] CH_ETX = 8'd3;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_NAK = 8'd21;
   localparam logic [7:0] CH_SP  = 8'd32;
   localparam logic [7:0] CH_DEL = 8'd127;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [0:0] REG_CANON = 1'd0;
   localparam logic [0:0] REG_ECHO  = 1'd1;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_out;
      logic       last;
      logic       line_end;
      logic       input_nonempty;
      logic       output_pending;
   } rsp_type;

   // datapath commands
   localparam logic [3:0] DC_NONE    = 4'd0;
   localparam logic [3:0] DC_APPEND  = 4'd1;  // store byte, length up
   localparam logic [3:0] DC_ERASE   = 4'd2;  // length down
   localparam logic [3:0] DC_CLRLINE = 4'd3;
   localparam logic [3:0] DC_RAWPUSH = 4'd4;
   localparam logic [3:0] DC_LREAD   = 4'd5;  // issue line store read at index
   localparam logic [3:0] DC_LPUSH   = 4'd6;  // push read line byte, index up
   localparam logic [3:0] DC_LFPUSH  = 4'd7;  // push LF, clear line
   localparam logic [3:0] DC_OPUSH   = 4'd8;
   localparam logic [3:0] DC_IPOP    = 4'd9;  // issue input queue read
   localparam logic [3:0] DC_OPOP    = 4'd10;
   localparam logic [3:0] DC_IDXCLR  = 4'd11;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] data;
   } dp_cmd_type;

   typedef struct packed {
      logic [LLW-1:0] line_length;
      logic [LLW-1:0] index;
      logic           in_empty;
      logic           out_empty;
      logic [7:0]     rd_data;
   } dp_stat_type;
endpackage
`default_nettype wire

[src/tld_datapath.sv]
// ----------------------------------------------------------------------------
// tld_datapath
// line store, input and output queues with their pointers
// ----------------------------------------------------------------------------
`default_nettype none
module tld_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tld_pkg::dp_cmd_type  dp_cmd,
   output tld_pkg::dp_stat_type      dp_stat
);
   logic [7:0] line_mem [tld_pkg::LINE_DEPTH];
   logic [7:0] in_mem   [tld_pkg::INPUT_DEPTH];
   logic [7:0] out_mem  [tld_pkg::OUTPUT_DEPTH];

   logic [tld_pkg::LLW-1:0] len_ff, len_in, idx_ff, idx_in;
   logic [tld_pkg::IW-1:0]  irp_ff, irp_in, iwp_ff, iwp_in, iwp_nx;
   logic [tld_pkg::OW-1:0]  orp_ff, orp_in, owp_ff, owp_in, owp_nx;
   logic [7:0] line_rd_ff, q_rd_ff, rd_sel_ff;
   logic       sel_line_ff;
   logic       in_we, out_we;
   logic [7:0] in_wd;

   assign iwp_nx = iwp_ff + 1'b1;
   assign owp_nx = owp_ff + 1'b1;

   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      irp_in = irp_ff;
      iwp_in = iwp_ff;
      orp_in = orp_ff;
      owp_in = owp_ff;
      in_we  = 1'b0;
      out_we = 1'b0;
      in_wd  = dp_cmd.data;
      unique case (dp_cmd.cmd)
         tld_pkg::DC_APPEND:  len_in = len_ff + 1'b1;
         tld_pkg::DC_ERASE:   len_in = len_ff - 1'b1;
         tld_pkg::DC_CLRLINE: len_in = '0;
         tld_pkg::DC_RAWPUSH: in_we = 1'b1;
         tld_pkg::DC_LPUSH: begin
            in_we  = 1'b1;
            in_wd  = line_rd_ff;
            idx_in = idx_ff + 1'b1;
         end
         tld_pkg::DC_LFPUSH: begin
            in_we  = 1'b1;
            in_wd  = tld_pkg::CH_LF;
            len_in = '0;
         end
         tld_pkg::DC_OPUSH: out_we = 1'b1;
         tld_pkg::DC_IPOP:  if (irp_ff != iwp_ff) irp_in = irp_ff + 1'b1;
         tld_pkg::DC_OPOP:  if (orp_ff != owp_ff) orp_in = orp_ff + 1'b1;
         tld_pkg::DC_IDXCLR: idx_in = '0;
         default: ;
      endcase
      if (in_we && iwp_nx != irp_ff) iwp_in = iwp_nx;
      if (out_we && owp_nx != orp_ff) owp_in = owp_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         idx_ff <= '0;
         irp_ff <= '0;
         iwp_ff <= '0;
         orp_ff <= '0;
         owp_ff <= '0;
      end else begin
         len_ff <= len_in;
         idx_ff <= idx_in;
         irp_ff <= irp_in;
         iwp_ff <= iwp_in;
         orp_ff <= orp_in;
         owp_ff <= owp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.cmd == tld_pkg::DC_APPEND)
         line_mem[len_ff[tld_pkg::LW-1:0]] <= dp_cmd.data;
      line_rd_ff <= line_mem[idx_ff[tld_pkg::LW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (in_we && iwp_nx != irp_ff) in_mem[iwp_ff] <= in_wd;
      if (dp_cmd.cmd == tld_pkg::DC_IPOP) q_rd_ff <= in_mem[irp_ff];
   end

   always_ff @(posedge clock) begin
      if (out_we && owp_nx != orp_ff) out_mem[owp_ff] <= dp_cmd.data;
      if (dp_cmd.cmd == tld_pkg::DC_OPOP) rd_sel_ff <= out_mem[orp_ff];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.cmd == tld_pkg::DC_IPOP) sel_line_ff <= 1'b1;
      else if (dp_cmd.cmd == tld_pkg::DC_OPOP) sel_line_ff <= 1'b0;
   end

   assign dp_stat.line_length = len_ff;
   assign dp_stat.index       = idx_ff;
   assign dp_stat.in_empty    = (irp_ff == iwp_ff);
   assign dp_stat.out_empty   = (orp_ff == owp_ff);
   assign dp_stat.rd_data     = sel_line_ff ? q_rd_ff : rd_sel_ff;
endmodule
`default_nettype wire

[src/tld_controller.sv]
// ----------------------------------------------------------------------------
// tld_controller
// sequences one item: decodes it, drives the datapath, issues results
// ----------------------------------------------------------------------------
`default_nettype none
module tld_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 canon,
   input  wire logic                 echo_en,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tld_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tld_pkg::rsp_type          rsp_data,
   output tld_pkg::dp_cmd_type       dp_cmd,
   input  wire tld_pkg::dp_stat_type dp_stat
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_ECHO  = 4'd2;  // emit up to three echo bytes
   localparam logic [3:0] S_COPYR = 4'd3;
   localparam logic [3:0] S_COPYW = 4'd4;
   localparam logic [3:0] S_LF    = 4'd5;
   localparam logic [3:0] S_RDW   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [3:0] S_ERW   = 4'd9;  // ctrl-u: erase one more byte, or stop at an empty line

   logic [3:0] st_ff, st_in;
   tld_pkg::req_type it_ff, it_in;
   logic [7:0] e0_ff, e1_ff, e2_ff, e0_in, e1_in, e2_in;
   logic [1:0] ecnt_ff, ecnt_in;   // echo bytes left
   logic       kill_ff, kill_in;   // ctrl-u: keep erasing
   logic       then_copy_ff, then_copy_in;
   logic       ov_ff, ov_in;
   tld_pkg::rsp_type o_ff, o_in;
   logic       busy_out;
   logic       fin_last;
   logic       printable;

   assign busy_out  = ov_ff && rsp_stall;
   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data  = o_ff;
   assign printable = (it_ff.data_in >= tld_pkg::CH_SP) && (it_ff.data_in < tld_pkg::CH_DEL);

   always_comb begin
      st_in = st_ff;
      it_in = it_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      ecnt_in = ecnt_ff;
      kill_in = kill_ff;
      then_copy_in = then_copy_ff;
      ov_in = ov_ff && rsp_stall;
      o_in = o_ff;
      fin_last = 1'b0;
      dp_cmd.cmd  = tld_pkg::DC_NONE;
      dp_cmd.data = it_ff.data_in;
      unique case (st_ff)
         S_IDLE: if (req_valid) begin
            it_in = req_data;
            st_in = S_DEC;
         end
         S_DEC: begin
            st_in = S_IDLE;
            kill_in = 1'b0;
            then_copy_in = 1'b0;
            ecnt_in = '0;
            unique case (it_ff.operation)
               tld_pkg::OP_KEY: begin
                  if (!canon) begin
                     dp_cmd.cmd = tld_pkg::DC_RAWPUSH;
                     e0_in = it_ff.data_in;
                     ecnt_in = 2'd1;
                  end else if (it_ff.data_in == tld_pkg::CH_LF ||
                               it_ff.data_in == tld_pkg::CH_CR) begin
                     dp_cmd.cmd = tld_pkg::DC_IDXCLR;
                     e0_in = tld_pkg::CH_LF;
                     ecnt_in = 2'd1;
                     then_copy_in = 1'b1;
                  end else if (it_ff.data_in == tld_pkg::CH_BS ||
                               it_ff.data_in == tld_pkg::CH_DEL ||
                               it_ff.data_in == tld_pkg::CH_NAK) begin
                     if (dp_stat.line_length != '0) begin
                        dp_cmd.cmd = tld_pkg::DC_ERASE;
                        e0_in = tld_pkg::CH_BS;
                        e1_in = tld_pkg::CH_SP;
                        e2_in = tld_pkg::CH_BS;
                        ecnt_in = 2'd3;
                        kill_in = (it_ff.data_in == tld_pkg::CH_NAK);
                     end
                  end else if (it_ff.data_in == tld_pkg::CH_ETX) begin
                     dp_cmd.cmd = tld_pkg::DC_CLRLINE;
                     e0_in = tld_pkg::CH_CARET;
                     e1_in = tld_pkg::CH_C;
                     e2_in = tld_pkg::CH_LF;
                     ecnt_in = 2'd3;
                  end else if (printable && dp_stat.line_length <
                               tld_pkg::LLW'(tld_pkg::LINE_DEPTH - 1)) begin
                     dp_cmd.cmd = tld_pkg::DC_APPEND;
                     e0_in = it_ff.data_in;
                     ecnt_in = 2'd1;
                  end
                  if (!echo_en) ecnt_in = '0;
                  if (then_copy_in) st_in = (ecnt_in != '0) ? S_ECHO : S_COPYR;
                  else if (ecnt_in != '0) st_in = S_ECHO;
                  else if (kill_in) st_in = S_ERW;
               end
               tld_pkg::OP_RDIN: begin
                  dp_cmd.cmd = tld_pkg::DC_IPOP;
                  st_in = S_RDW;
               end
               tld_pkg::OP_WROUT: dp_cmd.cmd = tld_pkg::DC_OPUSH;
               default: begin
                  dp_cmd.cmd = tld_pkg::DC_OPOP;
                  st_in = S_RDW;
               end
            endcase
         end
         S_ECHO: if (!busy_out) begin
            // last only when nothing more follows this echo byte
            fin_last = (ecnt_ff == 2'd1) &&
                       !(kill_ff && dp_stat.line_length != '0);
            ov_in = 1'b1;
            o_in.kind = tld_pkg::KIND_ECHO;
            o_in.data_out = e0_ff;
            o_in.last = fin_last;
            o_in.line_end = 1'b0;
            // a line end always leaves the input queue non-empty
            o_in.input_nonempty = !dp_stat.in_empty || then_copy_ff;
            o_in.output_pending = !dp_stat.out_empty;
            e0_in = e1_ff;
            e1_in = e2_ff;
            ecnt_in = ecnt_ff - 1'b1;
            if (ecnt_ff == 2'd1) begin
               if (then_copy_ff) st_in = S_COPYR;
               else if (kill_ff && dp_stat.line_length != '0) st_in = S_ERW;
               else st_in = S_IDLE;
            end
         end
         S_ERW: begin
            if (dp_stat.line_length == '0) st_in = S_IDLE;
            else begin
               dp_cmd.cmd = tld_pkg::DC_ERASE;
               e0_in = tld_pkg::CH_BS;
               e1_in = tld_pkg::CH_SP;
               e2_in = tld_pkg::CH_BS;
               ecnt_in = echo_en ? 2'd3 : 2'd0;
               st_in = echo_en ? S_ECHO : S_ERW;
            end
         end
         S_COPYR: begin
            if (dp_stat.index >= dp_stat.line_length) st_in = S_LF;
            else begin
               dp_cmd.cmd = tld_pkg::DC_LREAD;
               st_in = S_COPYW;
            end
         end
         S_COPYW: begin
            dp_cmd.cmd = tld_pkg::DC_LPUSH;
            st_in = S_COPYR;
         end
         S_LF: begin
            dp_cmd.cmd = tld_pkg::DC_LFPUSH;
            st_in = S_IDLE;
         end
         S_RDW: st_in = S_RD;
         S_RD: if (!busy_out) begin
            ov_in = 1'b1;
            o_in.last = 1'b1;
            o_in.input_nonempty = !dp_stat.in_empty;
            o_in.output_pending = !dp_stat.out_empty;
            // pointer already advanced; empty is seen via a sticky flag
            if (then_copy_ff) begin
               o_in.kind = tld_pkg::KIND_EMPTY;
               o_in.data_out = '0;
               o_in.line_end = 1'b0;
            end else begin
               o_in.kind = tld_pkg::KIND_BYTE;
               o_in.data_out = dp_stat.rd_data;
               o_in.line_end = canon && (it_ff.operation == tld_pkg::OP_RDIN) &&
                               (dp_stat.rd_data == tld_pkg::CH_LF);
            end
            st_in = S_IDLE;
         end
         default: st_in = S_DONE;
      endcase
      if (st_ff == S_DONE) st_in = S_IDLE;
      // remember whether the read found its queue empty
      if (st_ff == S_DEC && it_ff.operation == tld_pkg::OP_RDIN)
         then_copy_in = dp_stat.in_empty;
      if (st_ff == S_DEC && it_ff.operation == tld_pkg::OP_RDOUT)
         then_copy_in = dp_stat.out_empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         ecnt_ff <= '0;
         kill_ff <= 1'b0;
         then_copy_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         ecnt_ff <= ecnt_in;
         kill_ff <= kill_in;
         then_copy_ff <= then_copy_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      e0_ff <= e0_in;
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      o_ff  <= o_in;
   end
endmodule
`default_nettype wire

[src/tty_line_discipline_core.sv]
// ----------------------------------------------------------------------------
// tty_line_discipline_core
// canonical terminal line editor with input and output byte queues
// ----------------------------------------------------------------------------
// One item at a time. A write to the output queue is done in the decode
// state, a queue read waits for the registered queue data, an editing
// keystroke emits its echo bytes one by one, Ctrl-U erases and echoes byte
// by byte, and a line end copies the stored line into the input queue as a
// read and then a push per byte through the single read port of the line
// store, then pushes LF. A result register stands between the block and its
// consumer, and an echo or read waits there while the consumer stalls.
`default_nettype none
`include "tty_line_discipline_core_defines.svh"
module tty_line_discipline_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tld_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tld_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   logic canon_ff, echo_ff;
   logic wr;
   tld_pkg::dp_cmd_type  dp_cmd;
   tld_pkg::dp_stat_type dp_stat;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         canon_ff <= 1'b1;
         echo_ff  <= 1'b1;
      end else if (wr) begin
         if (paddr[2] == tld_pkg::REG_CANON) canon_ff <= pwdata[0];
         if (paddr[2] == tld_pkg::REG_ECHO)  echo_ff  <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         tld_pkg::REG_CANON: prdata[0] = canon_ff;
         default:            prdata[0] = echo_ff;
      endcase
   end

   tld_controller u_ctrl (
      .clock, .reset,
      .canon(canon_ff), .echo_en(echo_ff),
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .dp_cmd, .dp_stat
   );

   tld_datapath u_dp (
      .clock, .reset, .dp_cmd, .dp_stat
   );

   `TLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `TLD_ASSERT_IMP(a_line_bound, clock, reset, 1'b1, dp_stat.line_length < tld_pkg::LLW'(tld_pkg::LINE_DEPTH))
   `TLD_ASSERT_IMP(a_empty_nodata, clock, reset, rsp_valid && rsp_data.kind == tld_pkg::KIND_EMPTY, rsp_data.last && rsp_data.data_out == 8'd0)
endmodule
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// line discipline core: directed editing cases, then random keystroke, read
// and write traffic in both modes, checked against an in-bench predictor
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import tld_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   tty_line_discipline_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic canon_on, echo_on;
   logic [7:0] line_buf [LINE_DEPTH];
   int unsigned line_len;
   logic [7:0] inq [INPUT_DEPTH];
   int unsigned inq_rd, inq_wr;
   logic [7:0] outq [OUTPUT_DEPTH];
   int unsigned outq_rd, outq_wr;
   rsp_type step_rsps [$];
   rsp_type expected_rsps [$];

   bit failed = 1'b0;
   bit rx_idle_ok = 1'b1;
   bit tx_idle_ok = 1'b1;
   int hold_off = 0;
   int quiet_cycles = 0;

   function automatic void add_rsp(logic [1:0] kind, logic [7:0] b, logic le);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.data_out = b;
      r.line_end = le;
      step_rsps.push_back(r);
   endfunction

   function automatic void add_echo(logic [7:0] b);
      if (echo_on) add_rsp(KIND_ECHO, b, 1'b0);
   endfunction

   function automatic void in_push(logic [7:0] b);
      if ((inq_wr + 1) % INPUT_DEPTH != inq_rd) begin
         inq[inq_wr] = b;
         inq_wr = (inq_wr + 1) % INPUT_DEPTH;
      end
   endfunction

   function automatic void edit_line(logic [7:0] c);
      if (!canon_on) begin
         in_push(c);
         add_echo(c);
      end else if (c == CH_LF || c == CH_CR) begin
         add_echo(CH_LF);
         for (int i = 0; i < line_len; i++) in_push(line_buf[i]);
         in_push(CH_LF);
         line_len = 0;
      end else if (c == CH_BS || c == CH_DEL || c == CH_NAK) begin
         while (line_len > 0) begin
            line_len--;
            add_echo(CH_BS);
            add_echo(CH_SP);
            add_echo(CH_BS);
            if (c != CH_NAK) break;
         end
      end else if (c == CH_ETX) begin
         add_echo(CH_CARET);
         add_echo(CH_C);
         add_echo(CH_LF);
         line_len = 0;
      end else if (c >= CH_SP && c < CH_DEL && line_len < LINE_DEPTH - 1) begin
         line_buf[line_len] = c;
         line_len++;
         add_echo(c);
      end
   endfunction

   // works out the results of one item and queues them
   function automatic void predict_item(req_type q);
      logic [7:0] b;
      step_rsps.delete();
      case (q.operation)
         OP_KEY: edit_line(q.data_in);
         OP_RDIN: begin
            if (inq_rd == inq_wr) add_rsp(KIND_EMPTY, 8'd0, 1'b0);
            else begin
               b = inq[inq_rd];
               inq_rd = (inq_rd + 1) % INPUT_DEPTH;
               add_rsp(KIND_BYTE, b, canon_on && b == CH_LF);
            end
         end
         OP_WROUT: begin
            if ((outq_wr + 1) % OUTPUT_DEPTH != outq_rd) begin
               outq[outq_wr] = q.data_in;
               outq_wr = (outq_wr + 1) % OUTPUT_DEPTH;
            end
         end
         default: begin
            if (outq_rd == outq_wr) add_rsp(KIND_EMPTY, 8'd0, 1'b0);
            else begin
               b = outq[outq_rd];
               outq_rd = (outq_rd + 1) % OUTPUT_DEPTH;
               add_rsp(KIND_BYTE, b, 1'b0);
            end
         end
      endcase
      foreach (step_rsps[k]) begin
         step_rsps[k].last = (k == step_rsps.size() - 1);
         step_rsps[k].input_nonempty = (inq_rd != inq_wr);
         step_rsps[k].output_pending = (outq_rd != outq_wr);
         expected_rsps.push_back(step_rsps[k]);
      end
   endfunction

   // valid stays up after an accept until a gap or a drain drops it
   task automatic send_item(logic [1:0] op, logic [7:0] d);
      req_type q;
      int gap;
      q.operation = op;
      q.data_in = d;
      if (tx_idle_ok && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(q);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      // a silent item may still be in flight
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= addr; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == 3'(REG_CANON) << 2) canon_on = val[0];
      else if (addr == 3'(REG_ECHO) << 2) echo_on = val[0];
   endtask

   task automatic set_mode(logic canon, logic echo);
      drain_results();
      write_reg(3'(REG_CANON) << 2, {31'd0, canon});
      write_reg(3'(REG_ECHO) << 2, {31'd0, echo});
   endtask

   // result checking and receiver idling
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            failed = 1'b1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_data.kind); failed = 1'b1;
            end
            if (rsp_data.data_out !== e.data_out) begin
               $error("data_out: expected %0d, got %0d", e.data_out, rsp_data.data_out);
               failed = 1'b1;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_data.last); failed = 1'b1;
            end
            if (rsp_data.line_end !== e.line_end) begin
               $error("line_end: expected %0d, got %0d", e.line_end, rsp_data.line_end);
               failed = 1'b1;
            end
            if (rsp_data.input_nonempty !== e.input_nonempty) begin
               $error("input_nonempty: expected %0d, got %0d",
                      e.input_nonempty, rsp_data.input_nonempty);
               failed = 1'b1;
            end
            if (rsp_data.output_pending !== e.output_pending) begin
               $error("output_pending: expected %0d, got %0d",
                      e.output_pending, rsp_data.output_pending);
               failed = 1'b1;
            end
         end
      end
   end

   int rx_burst = 0;
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (rx_burst > 0) begin
         rx_burst <= rx_burst - 1;
         rsp_stall <= 1'b1;
      end else if (rx_idle_ok && $urandom_range(0, 4) == 0) begin
         rx_burst <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no accepted item, result or register access
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] printable();
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic test_line_editing();
      send_item(OP_RDIN, 8'd0);
      send_item(OP_RDOUT, 8'd0);
      send_item(OP_KEY, 8'd32);
      send_item(OP_KEY, 8'd126);
      send_item(OP_KEY, CH_BS);
      send_item(OP_KEY, CH_DEL);
      send_item(OP_KEY, CH_DEL);
      send_item(OP_KEY, CH_NAK);
      send_item(OP_KEY, 8'd0);
      send_item(OP_KEY, 8'd255);
      send_item(OP_KEY, 8'd128);
      for (int i = 0; i < 17; i++) send_item(OP_KEY, printable());
      send_item(OP_KEY, CH_CR);
      for (int i = 0; i < 17; i++) send_item(OP_RDIN, 8'd0);
      send_item(OP_KEY, 8'h41);
      send_item(OP_KEY, CH_ETX);
      send_item(OP_KEY, CH_LF);
      send_item(OP_RDIN, 8'd0);
      send_item(OP_WROUT, 8'd0);
      send_item(OP_WROUT, 8'd255);
      send_item(OP_RDOUT, 8'd0);
      send_item(OP_RDOUT, 8'd0);
   endtask

   task automatic test_raw_mode();
      set_mode(1'b0, 1'b1);
      send_item(OP_KEY, 8'd0);
      send_item(OP_KEY, CH_LF);
      send_item(OP_KEY, 8'd255);
      for (int i = 0; i < 4; i++) send_item(OP_RDIN, 8'd0);
      set_mode(1'b0, 1'b0);
      send_item(OP_KEY, 8'd7);
      send_item(OP_RDIN, 8'd0);
      set_mode(1'b1, 1'b0);
      send_item(OP_KEY, 8'h61);
      send_item(OP_KEY, CH_LF);
      send_item(OP_RDIN, 8'd0);
      send_item(OP_RDIN, 8'd0);
   endtask

   // mostly well-formed lines with edits, plus reads, writes and noise
   task automatic random_traffic(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_item(OP_KEY, printable());
         else if (r < 50) send_item(OP_KEY, $urandom_range(0, 1) ? CH_BS : CH_DEL);
         else if (r < 52) send_item(OP_KEY, CH_NAK);
         else if (r < 54) send_item(OP_KEY, CH_ETX);
         else if (r < 62) send_item(OP_KEY, $urandom_range(0, 1) ? CH_LF : CH_CR);
         else if (r < 66) send_item(OP_KEY, 8'($urandom_range(0, 255)));
         else if (r < 80) send_item(OP_RDIN, 8'($urandom_range(0, 255)));
         else if (r < 90) send_item(OP_WROUT, 8'($urandom_range(0, 255)));
         else send_item(OP_RDOUT, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_modes();
      set_mode(1'b1, 1'b1);
      random_traffic(100);
      set_mode(1'b0, 1'b1);
      random_traffic(40);
      set_mode(1'b1, 1'b0);
      random_traffic(40);
      set_mode(1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      // receiver holds off while echoing keystrokes keep arriving
      hold_off = 60;
      for (int i = 0; i < 30; i++) send_item(OP_KEY, printable());
      send_item(OP_KEY, CH_NAK);
      drain_results();
      random_traffic(20);
   endtask

   task automatic test_no_idling();
      tx_idle_ok = 1'b0;
      rx_idle_ok = 1'b0;
      random_traffic(60);
   endtask

   initial begin
      canon_on = 1'b1;
      echo_on = 1'b1;
      line_len = 0;
      inq_rd = 0; inq_wr = 0;
      outq_rd = 0; outq_wr = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_editing();
      test_raw_mode();
      test_random_modes();
      test_backpressure();
      test_no_idling();
      drain_results();
      if (!failed && expected_rsps.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
